>>> hdl/aapc_pkg.sv
`default_nettype none

package aapc_pkg;

   localparam int SAMPLE_W          = 12;
   localparam int CURRENT_W         = 22;
   localparam int STATUS_W          = 2;
   localparam int DEF_HISTORY_DEPTH = 10;
   localparam int DEF_SAMPLE_BITS   = 12;
   localparam int MAX_SAMPLE_BITS   = 16;

   localparam int KNOT_COUNT = 13;
   localparam int KNOT_IDX_W = 4;
   localparam int CODE_W     = 16;
   localparam int DX_W       = 9;
   localparam int DY_W       = 18;
   localparam int PROD_W     = DX_W + DY_W;
   localparam int QUO_W      = 18;

   localparam int EXTRA_W     = 48;
   localparam int FRAC_W      = 16;
   localparam int SLOPE_W     = 25;
   localparam int SLOPE_SPLIT = 13;

   localparam logic [CODE_W-1:0] KNOT_CODE [KNOT_COUNT] = '{
      16'd34717, 16'd34917, 16'd35118, 16'd35317, 16'd35530, 16'd35628, 16'd35781,
      16'd35919, 16'd36187, 16'd36420, 16'd36759, 16'd37156, 16'd37647
   };

   localparam logic signed [CURRENT_W-1:0] KNOT_UA [KNOT_COUNT] = '{
      -22'sd488000, -22'sd298000, -22'sd200000, -22'sd103000, -22'sd19700,
      -22'sd5000, 22'sd3560, 22'sd17500, 22'sd52800, 22'sd100000,
      22'sd192000, 22'sd326000, 22'sd478000
   };

   // Q16 extrapolation above the table
   localparam logic [SLOPE_W-1:0] EXTRA_SLOPE = 25'd20410466;
   localparam logic [SLOPE_SPLIT-1:0] SLOPE_LO = EXTRA_SLOPE[SLOPE_SPLIT-1:0];
   localparam logic [SLOPE_W-SLOPE_SPLIT-1:0] SLOPE_HI = EXTRA_SLOPE[SLOPE_W-1:SLOPE_SPLIT];
   localparam logic signed [EXTRA_W-1:0] EXTRA_OFFSET = 48'sd737138861670;

   localparam logic signed [CURRENT_W-1:0] UNDER_RANGE_UA = -22'sd500000;
   localparam logic signed [CURRENT_W-1:0] OUT_MAX = {1'b0, {(CURRENT_W-1){1'b1}}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_TABLE = 2'd0,
      STATUS_ABOVE = 2'd1,
      STATUS_BELOW = 2'd2
   } status_type;

endpackage

`default_nettype wire

>>> hdl/aapc_req_if.sv
`default_nettype none

interface aapc_req_if;
   import aapc_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] first_sample;
   logic [SAMPLE_W-1:0] second_sample;

   modport source (output valid, first_sample, second_sample, input ready);
   modport sink   (input valid, first_sample, second_sample, output ready);
endinterface

`default_nettype wire

>>> hdl/aapc_rsp_if.sv
`default_nettype none

interface aapc_rsp_if;
   import aapc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [CURRENT_W-1:0] current_microamps;
   logic [STATUS_W-1:0]         range_status;

   modport source (output valid, current_microamps, range_status, input ready);
   modport sink   (input valid, current_microamps, range_status, output ready);
endinterface

`default_nettype wire

>>> hdl/aapc_hist.sv
`default_nettype none

module aapc_hist #(
   parameter int HISTORY_DEPTH = aapc_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS   = aapc_pkg::DEF_SAMPLE_BITS,
   parameter int SUM_W         = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [aapc_pkg::SAMPLE_W-1:0] first_sample,
   input  wire logic [aapc_pkg::SAMPLE_W-1:0] second_sample,
   output logic                               done,
   output logic [SUM_W-1:0]                   sum
);
   import aapc_pkg::*;

   localparam int PAIRS   = HISTORY_DEPTH / 2;
   localparam int PTR_W   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int ROW_W   = 2 * SAMPLE_BITS;
   localparam int MAX_SUM = 2 * PAIRS * ((1 << SAMPLE_BITS) - 1);

   // one row per slot pair; an odd last slot is never written and reads as zero
   logic [ROW_W-1:0] pair_mem [PAIRS];

   logic [PAIRS-1:0]           valid_ff;
   logic [PTR_W-1:0]           pair_ff;
   logic [ROW_W-1:0]           rd_data_ff;
   logic [ROW_W-1:0]           new_ff;
   logic                       rd_valid_ff;
   logic                       upd_ff;
   logic                       done_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [SUM_W-1:0]           sum_in;
   logic [SUM_W-1:0]           old_lo;
   logic [SUM_W-1:0]           old_hi;
   logic [SUM_W-1:0]           new_lo;
   logic [SUM_W-1:0]           new_hi;
   logic [MAX_SAMPLE_BITS-1:0] first_ext;
   logic [MAX_SAMPLE_BITS-1:0] second_ext;

   assign first_ext  = MAX_SAMPLE_BITS'(first_sample);
   assign second_ext = MAX_SAMPLE_BITS'(second_sample);

   assign old_lo = rd_valid_ff ? SUM_W'(rd_data_ff[SAMPLE_BITS-1:0]) : '0;
   assign old_hi = rd_valid_ff ? SUM_W'(rd_data_ff[ROW_W-1:SAMPLE_BITS]) : '0;
   assign new_lo = SUM_W'(new_ff[SAMPLE_BITS-1:0]);
   assign new_hi = SUM_W'(new_ff[ROW_W-1:SAMPLE_BITS]);
   assign sum_in = sum_ff + new_lo + new_hi - old_lo - old_hi;

   always_ff @(posedge clock) begin
      if (start) begin
         rd_data_ff <= pair_mem[pair_ff];
         new_ff     <= {second_ext[SAMPLE_BITS-1:0], first_ext[SAMPLE_BITS-1:0]};
      end
      if (upd_ff) begin
         pair_mem[pair_ff] <= new_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         pair_ff     <= '0;
         rd_valid_ff <= 1'b0;
         upd_ff      <= 1'b0;
         done_ff     <= 1'b0;
         sum_ff      <= '0;
      end else begin
         upd_ff  <= start;
         done_ff <= upd_ff;
         if (start) begin
            rd_valid_ff <= valid_ff[pair_ff];
         end
         if (upd_ff) begin
            valid_ff[pair_ff] <= 1'b1;
            sum_ff            <= sum_in;
            if (pair_ff == PTR_W'(PAIRS - 1)) begin
               pair_ff <= '0;
            end else begin
               pair_ff <= pair_ff + 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign sum  = sum_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      start |-> !upd_ff && !done_ff)
      else $error("history access overlaps a pending update");

   a_upd_follows: assert property (@(posedge clock) disable iff (reset)
      start |=> upd_ff ##1 done_ff)
      else $error("history update sequence broken");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      pair_ff <= PTR_W'(PAIRS - 1))
      else $error("pair pointer out of range");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sum_ff) <= 32'(MAX_SUM))
      else $error("running sum exceeds history bound");

endmodule

`default_nettype wire

>>> hdl/aapc_div.sv
`default_nettype none

module aapc_div #(
   parameter int NUM_W = aapc_pkg::PROD_W,
   parameter int DEN_W = aapc_pkg::DX_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quo
);
   import aapc_pkg::*;

   // restoring division, two quotient bits per cycle
   localparam int STEPS = (NUM_W + 1) / 2;
   localparam int PAD_W = 2 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [PAD_W-1:0] num_ff;
   logic [PAD_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [PAD_W-1:0] num_in;
   logic [PAD_W-1:0] quo_in;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, num_in[PAD_W-1]};
         num_in = {num_in[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial  = trial - {1'b0, den_ff};
            quo_in = {quo_in[PAD_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[PAD_W-2:0], 1'b0};
         end
         rem_in = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= PAD_W'(num);
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff[NUM_W-1:0];

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      start |-> den != '0)
      else $error("divider started with zero divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a run");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0 && cnt_ff <= CNT_W'(STEPS))
      else $error("divider step count out of range");

endmodule

`default_nettype wire

>>> hdl/adc_average_piecewise_calibration.sv
// ADC averaging current meter with piecewise-linear calibration.
//
// req_ch (sink) carries two raw converter samples per transfer. They replace
// the oldest slot pair of the sample history; the history sum is then placed
// among 13 calibration breakpoints and turned into a current in microamps.
// rsp_ch (source) carries one result per request: current_microamps and
// range_status (in table, extrapolated above, below table).
//
// One request is processed at a time. The block updates the history, places
// the sum among the breakpoints, then interpolates (multiply and divide) inside
// the table, extrapolates and scales above it or takes the under-range value
// below it, and loads the result. The in-table time is set by the divider,
// which retires two quotient bits per cycle; the history itself is one
// pair-wide memory with a single read and write per request.
// The result sits in an output register; req_ch.ready returns as soon as the
// result is loaded, so the next request proceeds while rsp_ch is stalled. If
// the previous result is still unread when the next one is done, the block
// holds it and keeps req_ch.ready low until rsp_ch takes the pending result.
// Synchronous reset clears the history (all samples zero), the pair pointer
// and the output valid flag; the block is ready as soon as reset is released.
`default_nettype none

module adc_average_piecewise_calibration #(
   parameter int HISTORY_DEPTH = aapc_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS   = aapc_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   aapc_req_if.sink   req_ch,
   aapc_rsp_if.source rsp_ch
);
   import aapc_pkg::*;

   localparam int SUM_W   = $clog2(2 * (HISTORY_DEPTH / 2) * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int PLO_W   = SUM_W + SLOPE_SPLIT;
   localparam int PHI_W   = SUM_W + SLOPE_W - SLOPE_SPLIT;
   localparam int SCALE_W = EXTRA_W - FRAC_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HIST,
      S_LOCATE,
      S_MUL,
      S_DIVST,
      S_DIV,
      S_EXTRA,
      S_SCALE,
      S_FIN
   } state_type;

   state_type state_ff;

   logic                        hist_start;
   logic                        hist_done;
   logic [SUM_W-1:0]            hist_sum;
   logic                        div_start;
   logic                        div_done;
   logic [PROD_W-1:0]           div_quo;

   logic [31:0]                 sum_ext;
   logic [KNOT_IDX_W-1:0]       knot_idx;
   logic [KNOT_IDX_W-1:0]       lo_idx;
   logic [KNOT_IDX_W-1:0]       hi_idx;
   logic [31:0]                 dx_full;
   logic signed [CURRENT_W-1:0] dy_full;
   logic [CODE_W-1:0]           span_full;
   logic signed [EXTRA_W-1:0]   v_in;
   logic [SCALE_W-1:0]          scaled;

   logic [DX_W-1:0]             dx_ff;
   logic [DY_W-1:0]             dy_ff;
   logic [DX_W-1:0]             span_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic signed [CURRENT_W-1:0] base_ff;
   logic [PLO_W-1:0]            plo_ff;
   logic [PHI_W-1:0]            phi_ff;
   logic signed [EXTRA_W-1:0]   v_ff;
   logic signed [CURRENT_W-1:0] cur_ff;
   status_type                  status_ff;

   logic                        rsp_valid_ff;
   logic signed [CURRENT_W-1:0] rsp_cur_ff;
   status_type                  rsp_status_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign hist_start   = req_ch.valid && req_ch.ready;
   assign div_start    = (state_ff == S_DIVST);

   aapc_hist #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .SUM_W        (SUM_W)
   ) u_hist (
      .clock        (clock),
      .reset        (reset),
      .start        (hist_start),
      .first_sample (req_ch.first_sample),
      .second_sample(req_ch.second_sample),
      .done         (hist_done),
      .sum          (hist_sum)
   );

   aapc_div #(
      .NUM_W(PROD_W),
      .DEN_W(DX_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (prod_ff),
      .den  (span_ff),
      .done (div_done),
      .quo  (div_quo)
   );

   // breakpoint search: index of the first knot above the sum
   assign sum_ext = 32'(hist_sum);

   always_comb begin
      knot_idx = KNOT_IDX_W'(KNOT_COUNT);
      for (int i = KNOT_COUNT - 1; i >= 0; i--) begin
         if (sum_ext < 32'(KNOT_CODE[i])) begin
            knot_idx = KNOT_IDX_W'(i);
         end
      end
   end

   assign lo_idx    = (knot_idx == '0) ? '0 : knot_idx - 1'b1;
   assign hi_idx    = (knot_idx == KNOT_IDX_W'(KNOT_COUNT)) ?
                      KNOT_IDX_W'(KNOT_COUNT - 1) : knot_idx;
   assign dx_full   = sum_ext - 32'(KNOT_CODE[lo_idx]);
   assign dy_full   = KNOT_UA[hi_idx] - KNOT_UA[lo_idx];
   assign span_full = KNOT_CODE[hi_idx] - KNOT_CODE[lo_idx];

   assign v_in = $signed(EXTRA_W'({phi_ff, {SLOPE_SPLIT{1'b0}}}))
               + $signed(EXTRA_W'(plo_ff)) - EXTRA_OFFSET;

   assign scaled = v_ff[EXTRA_W-1] ? '0 : v_ff[EXTRA_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_FIN a transfer always reloads the output register
         if (rsp_ch.valid && rsp_ch.ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (hist_start) begin
                  state_ff <= S_HIST;
               end
            end
            S_HIST: begin
               if (hist_done) begin
                  state_ff <= S_LOCATE;
               end
            end
            S_LOCATE: begin
               if (knot_idx == '0) begin
                  cur_ff    <= UNDER_RANGE_UA;
                  status_ff <= STATUS_BELOW;
                  state_ff  <= S_FIN;
               end else if (knot_idx == KNOT_IDX_W'(KNOT_COUNT)) begin
                  plo_ff    <= PLO_W'(hist_sum * SLOPE_LO);
                  phi_ff    <= PHI_W'(hist_sum * SLOPE_HI);
                  status_ff <= STATUS_ABOVE;
                  state_ff  <= S_EXTRA;
               end else begin
                  dx_ff     <= dx_full[DX_W-1:0];
                  dy_ff     <= dy_full[DY_W-1:0];
                  span_ff   <= span_full[DX_W-1:0];
                  base_ff   <= KNOT_UA[lo_idx];
                  status_ff <= STATUS_TABLE;
                  state_ff  <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(dx_ff * dy_ff);
               state_ff <= S_DIVST;
            end
            S_DIVST: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  cur_ff   <= base_ff +
                              $signed({{(CURRENT_W-QUO_W){1'b0}}, div_quo[QUO_W-1:0]});
                  state_ff <= S_FIN;
               end
            end
            S_EXTRA: begin
               v_ff     <= v_in;
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               if (scaled[SCALE_W-1:CURRENT_W-1] != '0) begin
                  cur_ff <= OUT_MAX;
               end else begin
                  cur_ff <= $signed(scaled[CURRENT_W-1:0]);
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_cur_ff    <= cur_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.current_microamps = rsp_cur_ff;
   assign rsp_ch.range_status      = rsp_status_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      hist_start |=> state_ff == S_HIST)
      else $error("request transfer did not start a history update");

   a_hist_done_state: assert property (@(posedge clock) disable iff (reset)
      hist_done |-> state_ff == S_HIST)
      else $error("history result arrived outside its wait state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("quotient arrived outside its wait state");

   a_below_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_BELOW |-> rsp_cur_ff == UNDER_RANGE_UA)
      else $error("under-range result carries wrong current");

   a_above_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_ABOVE |-> !rsp_cur_ff[CURRENT_W-1])
      else $error("extrapolated current is negative");

endmodule

`default_nettype wire

>>> tb/sv/tb_adc_average_piecewise_calibration.sv
`default_nettype none

module tb_adc_average_piecewise_calibration;
   timeunit 1ns;
   timeprecision 1ps;

   import aapc_pkg::*;

   localparam int PAIRS = DEF_HISTORY_DEPTH / 2;
   localparam int MAX_PAIR_SUM = 2 * ((1 << SAMPLE_W) - 1);

   typedef struct {
      logic signed [CURRENT_W-1:0] microamps;
      status_type                  status;
   } reading_type;

   class calib_scoreboard;
      logic [SAMPLE_W-1:0] history [DEF_HISTORY_DEPTH];
      int unsigned         pair_idx;
      reading_type         pending_readings [$];
      int                  mismatches;
      int                  readings_seen;
      int                  status_hits [3];

      function new();
         foreach (history[i]) history[i] = '0;
         pair_idx = 0;
         mismatches = 0;
         readings_seen = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      // history sum without the pair the next transfer overwrites
      function int unsigned remaining_sum();
         int unsigned total;
         total = 0;
         foreach (history[i])
            if (i / 2 != pair_idx) total += history[i];
         return total;
      endfunction

      function void note_samples(logic [SAMPLE_W-1:0] first, logic [SAMPLE_W-1:0] second);
         int unsigned total;
         int          k;
         longint      dx, dy, span, v, ua;
         reading_type r;
         history[2*pair_idx]     = first;
         history[2*pair_idx + 1] = second;
         pair_idx = (pair_idx + 1 >= PAIRS) ? 0 : pair_idx + 1;
         total = 0;
         foreach (history[i]) total += history[i];
         k = KNOT_COUNT;
         for (int i = 0; i < KNOT_COUNT; i++) begin
            if (total < KNOT_CODE[i]) begin
               k = i;
               break;
            end
         end
         if (k == 0) begin
            ua = UNDER_RANGE_UA;
            r.status = STATUS_BELOW;
         end else if (k < KNOT_COUNT) begin
            dx   = longint'(total) - longint'(KNOT_CODE[k-1]);
            dy   = longint'(KNOT_UA[k]) - longint'(KNOT_UA[k-1]);
            span = longint'(KNOT_CODE[k]) - longint'(KNOT_CODE[k-1]);
            ua   = longint'(KNOT_UA[k-1]) + (dx * dy) / span;
            r.status = STATUS_TABLE;
         end else begin
            v = longint'(total) * longint'(EXTRA_SLOPE) - longint'(EXTRA_OFFSET);
            if (v < 0) v = 0;
            ua = v / 65536;
            if (ua > longint'(OUT_MAX)) ua = OUT_MAX;
            r.status = STATUS_ABOVE;
         end
         r.microamps = ua[CURRENT_W-1:0];
         pending_readings.push_back(r);
      endfunction

      function void check_reading(logic signed [CURRENT_W-1:0] microamps,
                                  logic [STATUS_W-1:0] status);
         reading_type r;
         readings_seen++;
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reading %0d: none pending, got %0d status %0d",
                        readings_seen, microamps, status);
            return;
         end
         r = pending_readings.pop_front();
         status_hits[r.status]++;
         if (microamps !== r.microamps || status !== r.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reading %0d: expected %0d %s, got %0d status %0d",
                        readings_seen, r.microamps, r.status.name(), microamps, status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   pairs_sent;
   int   drain_cycles;

   calib_scoreboard sb = new();

   aapc_req_if req_ch ();
   aapc_rsp_if rsp_ch ();

   adc_average_piecewise_calibration i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_reading(rsp_ch.current_microamps, rsp_ch.range_status);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_pair(logic [SAMPLE_W-1:0] first, logic [SAMPLE_W-1:0] second);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.first_sample  <= first;
      req_ch.second_sample <= second;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_samples(first, second);
      pairs_sent++;
   endtask

   // choose the pair that brings the history sum as close to target as it can
   task automatic send_toward(int target);
      int need;
      need = target - int'(sb.remaining_sum());
      if (need < 0) need = 0;
      if (need > MAX_PAIR_SUM) need = MAX_PAIR_SUM;
      send_pair(SAMPLE_W'(need / 2), SAMPLE_W'(need - need / 2));
   endtask

   task automatic send_random(int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_toward($urandom_range(40950, 34400));
         else if (pick < 75)
            send_toward(int'(KNOT_CODE[$urandom_range(KNOT_COUNT-1)]) + $urandom_range(2) - 1);
         else if (pick < 90)
            send_pair(SAMPLE_W'($urandom_range(4095)), SAMPLE_W'($urandom_range(4095)));
         else
            send_pair($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0);
      end
   endtask

   initial begin
      req_ch.valid         <= 1'b0;
      req_ch.first_sample  <= '0;
      req_ch.second_sample <= '0;
      reset                <= 1'b1;
      pairs_sent    = 0;
      send_idle_pct = 29;
      recv_idle_pct = 69;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // below range from the cleared history, then full scale
      send_pair('0, '0);
      send_pair('1, '0);
      send_pair('0, '1);
      repeat (5) send_pair('1, '1);
      // edges of the table, an inner breakpoint and full scale
      send_toward(37647);
      send_toward(37646);
      send_toward(34717);
      send_toward(34716);
      send_toward(36187);
      send_toward(40950);

      send_random(420);

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_readings.size() != 0);

      send_idle_pct = 69;
      recv_idle_pct = 29;
      send_random(420);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(410);
      req_ch.valid <= 1'b0;

      drain_cycles = 0;
      while (sb.pending_readings.size() != 0 && drain_cycles < 50000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (40) @(posedge clock);

      $display("Sent %0d sample pairs; readings in table %0d, above %0d, below %0d.",
               pairs_sent, sb.status_hits[STATUS_TABLE], sb.status_hits[STATUS_ABOVE],
               sb.status_hits[STATUS_BELOW]);
      $display("Mismatches %0d, readings still pending %0d.",
               sb.mismatches, sb.pending_readings.size());
      if (sb.mismatches == 0 && sb.pending_readings.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
hdl/aapc_pkg.sv
hdl/aapc_req_if.sv
hdl/aapc_rsp_if.sv
hdl/aapc_hist.sv
hdl/aapc_div.sv
hdl/adc_average_piecewise_calibration.sv
tb/sv/tb_adc_average_piecewise_calibration.sv
